FILE: design/sigmoid_neuron_unit_core_macros.svh
// Assertion macros shared by the sigmoid neuron design files.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SIGMOID_NEURON_UNIT_CORE_MACROS_SVH
`define SIGMOID_NEURON_UNIT_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every edge outside reset.
`define SNU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SNU_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define SNU_ASSERT(lbl, prop, msg)
`define SNU_ASSERT_RST(lbl, prop, msg)

`endif

`endif

FILE: design/snu_pkg.sv
// Shared constants, types and the elaboration-time sigmoid table builder.
// No dependencies; used by snu_act and sigmoid_neuron_unit_core.
package snu_pkg;

    localparam int DATA_WIDTH_DEF  = 16;
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int ACC_W           = 40;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // Item kinds carried on the slave-side tuser.
    localparam logic FUNC_FF  = 1'b0;
    localparam logic FUNC_REC = 1'b1;

    // Register selects, taken from paddr[2].
    localparam logic REG_BIAS    = 1'b0;
    localparam logic REG_RWEIGHT = 1'b1;

    typedef logic signed [ACC_W-1:0] t_acc;

    // Restoring long division, only ever evaluated while elaborating the table.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-a) in Q2.30: series for exp(-a/8), then squared three times.
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] a);
        logic [63:0]        y;
        logic [63:0]        term;
        logic [63:0]        z;
        logic signed [63:0] acc_s;
        y     = a >> 3;
        term  = Q30_ONE;
        acc_s = $signed(Q30_ONE);
        for (int k = 1; k <= 30; k++) begin
            term = udiv64((term * y) >> 30, 64'(k));
            if (k[0]) begin
                acc_s = acc_s - $signed(term);
            end else begin
                acc_s = acc_s + $signed(term);
            end
        end
        if (acc_s < 0) begin
            acc_s = '0;
        end
        if (acc_s > $signed(Q30_ONE)) begin
            acc_s = $signed(Q30_ONE);
        end
        z = $unsigned(acc_s);
        for (int s = 0; s < 3; s++) begin
            z = (z * z + (Q30_ONE >> 1)) >> 30;
        end
        return z;
    endfunction

    // Rounded sigmoid at the middle of bin i, scaled by 2^frac (ties round up).
    function automatic logic [63:0] sig_entry(input int i, input int depth, input int frac);
        logic signed [63:0] mid;
        logic [63:0]        mag;
        logic [63:0]        e;
        logic [63:0]        d;
        logic [63:0]        num;
        mid = $signed(udiv64(64'(2 * i + 1) << 33, 64'(depth))) - $signed(64'd1 << 33);
        mag = (mid < 0) ? $unsigned(-mid) : $unsigned(mid);
        if (mag > (64'd8 << 30)) begin
            mag = 64'd8 << 30;
        end
        e   = exp_neg_q30(mag);
        d   = Q30_ONE + e;
        num = (mid >= 0) ? (Q30_ONE << (frac + 1)) : (e << (frac + 1));
        return udiv64(num + d, d << 1);
    endfunction

endpackage

FILE: design/snu_act.sv
// Activation stage: floor to Q4.12, clamp, sigmoid table look-up, bias, output register.
// Depends on snu_pkg and sigmoid_neuron_unit_core_macros.svh.
`include "sigmoid_neuron_unit_core_macros.svh"

module snu_act #(
    parameter int DATA_WIDTH  = snu_pkg::DATA_WIDTH_DEF,
    parameter int TABLE_DEPTH = snu_pkg::TABLE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  snu_pkg::t_acc                i_sum,
    input  logic signed [DATA_WIDTH-1:0] i_bias,
    output logic                         o_valid,
    input  logic                         i_m_ready,
    output logic signed [DATA_WIDTH-1:0] o_activation,
    output logic                         o_saturated
);
    import snu_pkg::*;

    localparam int DW    = DATA_WIDTH;
    localparam int FRAC  = DW - 4;
    localparam int ENT_W = FRAC + 1;
    localparam int IW    = $clog2(TABLE_DEPTH);
    localparam int PRE_W = ACC_W - FRAC;
    localparam int CMP_W = ((PRE_W > DW) ? PRE_W : DW) + 1;
    localparam int MUL_W = DW + IW + 1;

    localparam logic signed [CMP_W-1:0] PRE_HI = {{(CMP_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [CMP_W-1:0] PRE_LO = {{(CMP_W-DW+1){1'b1}}, {(DW-1){1'b0}}};
    localparam logic signed [DW:0]      ACT_HI = {2'b00, {(DW-1){1'b1}}};
    localparam logic signed [DW:0]      ACT_LO = {2'b11, {(DW-1){1'b0}}};

    logic [ENT_W-1:0] w_tab [TABLE_DEPTH];

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_tab
        localparam logic [63:0] ENT = sig_entry(g, TABLE_DEPTH, FRAC);
        assign w_tab[g] = ENT[ENT_W-1:0];
    end

    logic signed [PRE_W-1:0] w_pre;
    logic signed [CMP_W-1:0] w_pre_x;
    logic signed [DW-1:0]    w_pre_c;
    logic                    w_pre_sat;
    logic [DW-1:0]           w_ofs;
    logic [MUL_W-1:0]        w_scaled;
    logic [IW-1:0]           w_idx;
    logic [ENT_W-1:0]        w_ent;
    logic signed [DW:0]      w_act_raw;
    logic signed [DW-1:0]    w_act;
    logic                    w_sat;
    logic                    w_load;

    logic                    r_valid;
    logic signed [DW-1:0]    r_act;
    logic                    r_sat;

    always_comb begin
        // Dropping the fraction bits of a two's complement value floors it.
        w_pre     = i_sum[ACC_W-1:FRAC];
        w_pre_x   = CMP_W'(w_pre);
        w_pre_sat = 1'b0;
        if (w_pre_x > PRE_HI) begin
            w_pre_c   = PRE_HI[DW-1:0];
            w_pre_sat = 1'b1;
        end else if (w_pre_x < PRE_LO) begin
            w_pre_c   = PRE_LO[DW-1:0];
            w_pre_sat = 1'b1;
        end else begin
            w_pre_c = w_pre_x[DW-1:0];
        end
        // Offset from the most negative value, then scaled onto the bins.
        w_ofs     = {~w_pre_c[DW-1], w_pre_c[DW-2:0]};
        w_scaled  = MUL_W'(w_ofs) * MUL_W'(TABLE_DEPTH);
        w_idx     = w_scaled[DW+IW-1:DW];
        w_ent     = w_tab[w_idx];
        w_act_raw = (DW+1)'($signed({1'b0, w_ent})) + (DW+1)'(i_bias);
        w_sat     = w_pre_sat;
        if (w_act_raw > ACT_HI) begin
            w_act = ACT_HI[DW-1:0];
            w_sat = 1'b1;
        end else if (w_act_raw < ACT_LO) begin
            w_act = ACT_LO[DW-1:0];
            w_sat = 1'b1;
        end else begin
            w_act = w_act_raw[DW-1:0];
        end
    end

    assign o_ready = !r_valid || i_m_ready;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_act <= w_act;
            r_sat <= w_sat;
        end
    end

    assign o_valid      = r_valid;
    assign o_activation = r_act;
    assign o_saturated  = r_sat;

    `SNU_ASSERT(a_load_shows, w_load |=> r_valid, "loaded result not presented")
    `SNU_ASSERT(a_taken_clears, (r_valid && i_m_ready && !i_valid) |=> !r_valid, "taken result repeated")
    `SNU_ASSERT(a_zero_bias_no_clamp, (w_load && !w_pre_sat && (i_bias == '0)) |=> !r_sat, "clamp flagged without cause")

endmodule

FILE: design/sigmoid_neuron_unit_core.sv
// Top level of the fixed-point sigmoid neuron: stream ports, APB registers, datapath.
// Depends on snu_pkg, snu_act and sigmoid_neuron_unit_core_macros.svh.
//
//  Channel   Direction  Beat carries
//  s_axis    in         tdata: x_value, in_weight, hidden_prev; tuser: func; tlast: last_term
//  m_axis    out        tdata: activation; tuser: saturated
//  apb       in/out     bias_value at 0x0, recurrent_weight at 0x4
//
// One item is accepted per cycle for as long as the result side keeps up; each item
// passes in turn through the input, product, sum and output registers.
// The accumulator loop is a single saturating add per unstalled cycle in the sum stage.
// Reset is synchronous: it empties the pipeline, clears the accumulator and the two
// registers. The sigmoid table is constant logic and needs no clearing pass.
// Each stage holds while the one behind it is full and stalled, so a stall on m_axis
// backs up into s_axis_tready only once every stage is occupied.
`include "sigmoid_neuron_unit_core_macros.svh"

module sigmoid_neuron_unit_core #(
    parameter int DATA_WIDTH  = snu_pkg::DATA_WIDTH_DEF,
    parameter int TABLE_DEPTH = snu_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Slave side.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata, from bit 0: x_value, in_weight, hidden_prev, zero padding.
    input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    // tuser: func.
    input  logic                                   s_axis_tuser,
    input  logic                                   s_axis_tlast,
    // Master side.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata, from bit 0: activation, zero padding.
    output logic [((DATA_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
    // tuser: saturated.
    output logic                                   m_axis_tuser,
    // Configuration port.
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [snu_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [snu_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [snu_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);
    import snu_pkg::*;

    localparam int DW     = DATA_WIDTH;
    localparam int PROD_W = 2 * DW;
    localparam int SUM_W  = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 2;
    localparam int OUT_W  = ((DW + 7) / 8) * 8;

    localparam logic signed [SUM_W-1:0] ACC_HI = {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] ACC_LO = {{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

    // Clamp a wide sum to the accumulator's signed range.
    function automatic t_acc sat_acc(input logic signed [SUM_W-1:0] v);
        t_acc res;
        if (v > ACC_HI) begin
            res = ACC_HI[ACC_W-1:0];
        end else if (v < ACC_LO) begin
            res = ACC_LO[ACC_W-1:0];
        end else begin
            res = v[ACC_W-1:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers. paddr[2] picks the register; the low
    // address bits are byte lanes and are not decoded.
    // ------------------------------------------------------------------
    logic signed [DW-1:0] r_bias;
    logic signed [DW-1:0] r_rweight;
    logic                 w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias    <= '0;
            r_rweight <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_BIAS:    r_bias    <= pwdata[DW-1:0];
                REG_RWEIGHT: r_rweight <= pwdata[DW-1:0];
                default:     r_bias    <= r_bias;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_BIAS:    prdata = APB_DATA_W'(r_bias);
            REG_RWEIGHT: prdata = APB_DATA_W'(r_rweight);
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline handshake. Each stage takes a new entry when it is empty
    // or when its current entry moves on in the same cycle.
    // ------------------------------------------------------------------
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;

    logic r_v1;
    logic r_v2;
    logic r_v3;

    assign rdy3          = !r_v3 || rdy4;
    assign rdy2          = !r_v2 || rdy3;
    assign rdy1          = !r_v1 || rdy2;
    assign s_axis_tready = rdy1;

    // Stage 1: input register.
    logic                 r_func1;
    logic                 r_last1;
    logic signed [DW-1:0] r_x1;
    logic signed [DW-1:0] r_w1;
    logic signed [DW-1:0] r_h1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && rdy1) begin
            r_func1 <= s_axis_tuser;
            r_last1 <= s_axis_tlast;
            r_x1    <= s_axis_tdata[DW-1:0];
            r_w1    <= s_axis_tdata[2*DW-1:DW];
            r_h1    <= s_axis_tdata[3*DW-1:2*DW];
        end
    end

    // Stage 2: both full-precision products.
    logic                     r_func2;
    logic                     r_last2;
    logic signed [PROD_W-1:0] r_p1;
    logic signed [PROD_W-1:0] r_p2;
    logic signed [PROD_W-1:0] n_p1;
    logic signed [PROD_W-1:0] n_p2;

    always_comb begin
        n_p1 = PROD_W'(r_x1) * PROD_W'(r_w1);
        n_p2 = PROD_W'(r_rweight) * PROD_W'(r_h1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1 && rdy2) begin
            r_func2 <= r_func1;
            r_last2 <= r_last1;
            r_p1    <= n_p1;
            r_p2    <= n_p2;
        end
    end

    // Stage 3: accumulate or form the recurrent sum. A feed-forward term
    // only leaves a result when it closes the dot product; the accumulator
    // is then cleared for the next one.
    t_acc r_acc;
    t_acc r_sum3;
    t_acc w_ff_sat;
    t_acc w_rec1;
    t_acc w_rec_sat;
    logic w_move3;

    always_comb begin
        w_ff_sat  = sat_acc(SUM_W'(r_acc) + SUM_W'(r_p1));
        w_rec1    = sat_acc(SUM_W'(r_p1));
        w_rec_sat = sat_acc(SUM_W'(w_rec1) + SUM_W'(r_p2));
    end

    assign w_move3 = r_v2 && rdy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3  <= 1'b0;
            r_acc <= '0;
        end else if (w_move3) begin
            if (r_func2 == FUNC_REC) begin
                r_v3 <= 1'b1;
            end else begin
                r_v3  <= r_last2;
                r_acc <= r_last2 ? '0 : w_ff_sat;
            end
        end else if (rdy3) begin
            r_v3 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move3) begin
            r_sum3 <= (r_func2 == FUNC_REC) ? w_rec_sat : w_ff_sat;
        end
    end

    // Stage 4: activation and output register.
    logic signed [DW-1:0] w_act;

    snu_act #(
        .DATA_WIDTH  (DATA_WIDTH),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_act (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_v3),
        .o_ready      (rdy4),
        .i_sum        (r_sum3),
        .i_bias       (r_bias),
        .o_valid      (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .o_activation (w_act),
        .o_saturated  (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_W'($unsigned(w_act));

    `SNU_ASSERT_RST(a_rst_empty, !i_rst_n |=> (!r_v1 && !r_v2 && !r_v3), "pipeline not empty after reset")
    `SNU_ASSERT(a_term_silent, (w_move3 && (r_func2 == FUNC_FF) && !r_last2) |=> !r_v3, "open term produced a result")
    `SNU_ASSERT(a_close_clears, (w_move3 && (r_func2 == FUNC_FF) && r_last2) |=> (r_acc == '0), "accumulator kept after last term")
    `SNU_ASSERT(a_rec_keeps_acc, (w_move3 && (r_func2 == FUNC_REC)) |=> $stable(r_acc), "recurrent beat touched accumulator")

endmodule
